>>> design/ktt_pkg.sv
// Package with the types and constants shared by the keyed target table.
package ktt_pkg;

  localparam int unsigned KeyW   = 24;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned CountW = 16;
  localparam int unsigned MsW    = 22;
  localparam int unsigned AltW   = 18;
  localparam int unsigned StatW  = 3;
  localparam int unsigned CntOutW = 9;
  localparam int unsigned SlotOutW = 8;

  localparam logic signed [32:0] LatLimit = 33'sd754974720;
  localparam logic signed [32:0] LonLimit = 33'sd1509949440;
  localparam logic [9:0] UsPerMs = 10'd1000;
  localparam logic [CountW-1:0] CountMax = 16'hFFFF;

  localparam logic [2:0] RegExpiry  = 3'd0;
  localparam logic [2:0] RegPosStale = 3'd1;
  localparam logic [2:0] RegSanity  = 3'd2;
  localparam logic [2:0] RegAltEn   = 3'd3;
  localparam logic [2:0] RegAltCeil = 3'd4;

  typedef enum logic [StatW-1:0] {
    StNew     = 3'd0,
    StUpdated = 3'd1,
    StFix     = 3'd2,
    StEvicted = 3'd3,
    StSanity  = 3'd4,
    StAlt     = 3'd5,
    StAged    = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    FsmIdle,
    FsmScan,
    FsmDrain,
    FsmCommit,
    FsmOut
  } fsm_e;

  // Token that travels along the row of cells during one scan.
  typedef struct packed {
    logic             func;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] exp_us;
    logic [TimeW-1:0] pos_us;
  } scan_cmd_t;

  // Result token accumulated as it passes each cell.
  typedef struct packed {
    logic             found;
    logic [11:0]      found_idx;
    logic             have_free;
    logic [11:0]      free_idx;
    logic [TimeW-1:0] oldest_time;
    logic [11:0]      oldest_idx;
    logic [12:0]      expired;
  } scan_res_t;

  // Write command from the controller to one cell.
  typedef struct packed {
    logic             fresh;
    logic [KeyW-1:0]  key;
    logic [TimeW-1:0] now;
    logic             has_pos;
  } cell_wr_t;

endpackage

>>> design/ktt_cell.sv
// One table slot that merges its state into the scan token passing by.
module ktt_cell #(
  parameter int unsigned IdxW = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IdxW-1:0]       my_idx_i,
  input  logic                  scan_i,
  input  ktt_pkg::scan_cmd_t    cmd_i,
  input  ktt_pkg::scan_res_t    res_i,
  output ktt_pkg::scan_cmd_t    cmd_o,
  output ktt_pkg::scan_res_t    res_o,
  output logic                  scan_o,
  input  logic                  wr_i,
  input  ktt_pkg::cell_wr_t     wr_data_i,
  output logic [ktt_pkg::CountW-1:0] count_o,
  output logic                  pos_valid_o
);

  logic                        occ_q, occ_d;
  logic                        pv_q, pv_d;
  logic [ktt_pkg::KeyW-1:0]    key_q, key_d;
  logic [ktt_pkg::TimeW-1:0]   seen_q, seen_d;
  logic [ktt_pkg::TimeW-1:0]   ptime_q, ptime_d;
  logic [ktt_pkg::CountW-1:0]  cnt_q, cnt_d;
  ktt_pkg::scan_cmd_t          cmd_q;
  ktt_pkg::scan_res_t          res_q, res_d;
  logic                        scan_q;
  logic signed [ktt_pkg::TimeW:0] age_seen, age_pos;
  logic                        expire, stale;
  logic [ktt_pkg::CountW-1:0]  base_cnt;

  always_comb begin
    age_seen = $signed({1'b0, cmd_i.now}) - $signed({1'b0, seen_q});
    age_pos  = $signed({1'b0, cmd_i.now}) - $signed({1'b0, ptime_q});
    expire = occ_q && !age_seen[ktt_pkg::TimeW] &&
             (age_seen[ktt_pkg::TimeW-1:0] >= cmd_i.exp_us);
    stale  = pv_q && !age_pos[ktt_pkg::TimeW] &&
             (age_pos[ktt_pkg::TimeW-1:0] >= cmd_i.pos_us);
    res_d = res_i;
    occ_d = occ_q; pv_d = pv_q; key_d = key_q; seen_d = seen_q;
    ptime_d = ptime_q; cnt_d = cnt_q;
    if (scan_i) begin
      if (cmd_i.func) begin
        if (expire) begin
          occ_d = 1'b0;
          res_d.expired = res_i.expired + 13'd1;
        end else if (occ_q && stale) begin
          pv_d = 1'b0;
        end
      end else begin
        if (occ_q && key_q == cmd_i.key && !res_i.found) begin
          res_d.found = 1'b1;
          res_d.found_idx = 12'(my_idx_i);
        end
        if (!occ_q && !res_i.have_free) begin
          res_d.have_free = 1'b1;
          res_d.free_idx = 12'(my_idx_i);
        end
        if (my_idx_i == '0 || seen_q < res_i.oldest_time) begin
          res_d.oldest_time = seen_q;
          res_d.oldest_idx = 12'(my_idx_i);
        end
      end
    end
    if (wr_i) begin
      base_cnt = wr_data_i.fresh ? '0 : cnt_q;
      occ_d = 1'b1;
      key_d = wr_data_i.key;
      seen_d = wr_data_i.now;
      cnt_d = (base_cnt == ktt_pkg::CountMax) ? base_cnt : base_cnt + 16'd1;
      if (wr_data_i.fresh) pv_d = 1'b0;
      if (wr_data_i.has_pos) begin
        pv_d = 1'b1;
        ptime_d = wr_data_i.now;
      end
    end else begin
      base_cnt = cnt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q  <= 1'b0;
      pv_q   <= 1'b0;
      scan_q <= 1'b0;
    end else begin
      occ_q  <= occ_d;
      pv_q   <= pv_d;
      scan_q <= scan_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    seen_q  <= seen_d;
    ptime_q <= ptime_d;
    cnt_q   <= cnt_d;
    cmd_q   <= cmd_i;
    res_q   <= res_d;
  end

  assign cmd_o = cmd_q;
  assign res_o = res_q;
  assign scan_o = scan_q;
  assign count_o = cnt_q;
  assign pos_valid_o = pv_q;

endmodule

>>> design/keyed_target_table_with_aging.sv
// Top level of the keyed target table: stream ports, APB registers, cell row and control.
//
// Usage: one word on the s_axis side is one item, one word on the m_axis side is its
// single result. s_axis_tdata holds func, key, time, position flag, latitude, longitude,
// altitude flag and altitude, packed from bit 0 up. m_axis_tdata holds status, slot,
// entry message count, entry position valid, expired count, live total and live peak
// from bit 0 up.
// Each ingest passes through the filters; a rejected ingest goes straight to its result.
// Otherwise a token walks the row of CAPACITY cells, one cell per cycle. For an ingest
// the controller then writes the chosen cell and builds the result. One item is in flight
// at a time. s_axis_tready is high while no item is in work; a result waits in the output
// register until the receiver takes it, and the next item is accepted once the result
// has gone.
// Reset clears every slot at once, the live and peak counts, and loads the register
// defaults. The APB port writes registers at byte address 4*i and reads them back.
module keyed_target_table_with_aging #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // func, key, time, position flag, latitude, longitude, altitude flag,
  // altitude, zero fill
  input  logic [159:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status, slot, entry message count, entry position valid, expired count,
  // live total, live peak, zero fill
  output logic [55:0]  m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LiveW = $clog2(CAPACITY + 1);

  logic [ktt_pkg::MsW-1:0]  expiry_q, pstale_q;
  logic                     sanity_q, alten_q;
  logic [ktt_pkg::AltW-1:0] ceil_q;

  ktt_pkg::fsm_e state_q, state_d;
  logic [LiveW-1:0] live_q, live_d, peak_q, peak_d;
  logic [IdxW:0]    cnt_q, cnt_d;
  logic [159:0]     item_q;
  logic [55:0]      out_q, out_d;
  logic             out_v_q, out_v_d;
  logic [ktt_pkg::TimeW-1:0] exp_us_q, pos_us_q;

  // Register port.
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= 22'd60000;
      pstale_q <= 22'd30000;
      sanity_q <= 1'b1;
      alten_q  <= 1'b0;
      ceil_q   <= 18'sd60000;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        ktt_pkg::RegExpiry:   expiry_q <= pwdata[ktt_pkg::MsW-1:0];
        ktt_pkg::RegPosStale: pstale_q <= pwdata[ktt_pkg::MsW-1:0];
        ktt_pkg::RegSanity:   sanity_q <= pwdata[0];
        ktt_pkg::RegAltEn:    alten_q  <= pwdata[0];
        ktt_pkg::RegAltCeil:  ceil_q   <= pwdata[ktt_pkg::AltW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      ktt_pkg::RegExpiry:   prdata = 32'(expiry_q);
      ktt_pkg::RegPosStale: prdata = 32'(pstale_q);
      ktt_pkg::RegSanity:   prdata = 32'(sanity_q);
      ktt_pkg::RegAltEn:    prdata = 32'(alten_q);
      ktt_pkg::RegAltCeil:  prdata = 32'(ceil_q);
      default:              prdata = '0;
    endcase
  end

  // Item fields.
  logic        f_func, f_haspos, f_hasalt;
  logic [23:0] f_key;
  logic [47:0] f_time;
  logic signed [31:0] f_lat, f_lon;
  logic signed [17:0] f_alt;
  assign f_func   = item_q[0];
  assign f_key    = item_q[24:1];
  assign f_time   = item_q[72:25];
  assign f_haspos = item_q[73];
  assign f_lat    = item_q[105:74];
  assign f_lon    = item_q[137:106];
  assign f_hasalt = item_q[138];
  assign f_alt    = item_q[156:139];

  logic pos_bad, alt_bad;
  always_comb begin
    pos_bad = ($signed({f_lat[31], f_lat}) < -ktt_pkg::LatLimit) ||
              ($signed({f_lat[31], f_lat}) > ktt_pkg::LatLimit) ||
              ($signed({f_lon[31], f_lon}) < -ktt_pkg::LonLimit) ||
              ($signed({f_lon[31], f_lon}) > ktt_pkg::LonLimit) ||
              (f_lat == '0 && f_lon == '0);
    alt_bad = f_alt > $signed(ceil_q);
  end

  // Cell row.
  ktt_pkg::scan_cmd_t cmd_c [CAPACITY+1];
  ktt_pkg::scan_res_t res_c [CAPACITY+1];
  logic               scan_c [CAPACITY+1];
  logic [ktt_pkg::CountW-1:0] cell_cnt [CAPACITY];
  logic               cell_pv [CAPACITY];
  logic               scan_start;
  logic [IdxW-1:0]    wr_idx_q, wr_idx_d;
  logic               wr_en;
  ktt_pkg::cell_wr_t  wr_data;
  ktt_pkg::scan_res_t res_q;
  logic               fresh_q, fresh_d, evict_q, evict_d, found_q, found_d;

  assign scan_c[0] = scan_start;
  assign cmd_c[0] = '{func: f_func, key: f_key, now: f_time,
                      exp_us: exp_us_q, pos_us: pos_us_q};
  assign res_c[0] = '0;
  assign wr_data = '{fresh: fresh_q, key: f_key, now: f_time, has_pos: f_haspos};

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    ktt_cell #(.IdxW(IdxW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .my_idx_i   (IdxW'(g)),
      .scan_i     (scan_c[g]),
      .cmd_i      (cmd_c[g]),
      .res_i      (res_c[g]),
      .cmd_o      (cmd_c[g+1]),
      .res_o      (res_c[g+1]),
      .scan_o     (scan_c[g+1]),
      .wr_i       (wr_en && wr_idx_q == IdxW'(g)),
      .wr_data_i  (wr_data),
      .count_o    (cell_cnt[g]),
      .pos_valid_o(cell_pv[g])
    );
  end

  logic pv_before_q, pv_before_d;

  always_comb begin
    state_d = state_q;
    live_d = live_q; peak_d = peak_q; cnt_d = cnt_q;
    out_d = out_q; out_v_d = out_v_q;
    scan_start = 1'b0; wr_en = 1'b0;
    wr_idx_d = wr_idx_q; fresh_d = fresh_q; evict_d = evict_q; found_d = found_q;
    pv_before_d = pv_before_q;
    if (out_v_q && m_axis_tready) out_v_d = 1'b0;
    case (state_q)
      ktt_pkg::FsmIdle: begin
        if (s_axis_tvalid && s_axis_tready) state_d = ktt_pkg::FsmScan;
      end
      ktt_pkg::FsmScan: begin
        if (!f_func && sanity_q && f_haspos && pos_bad) begin
          out_d = {1'b0, 9'(peak_q), 9'(live_q), 9'd0, 1'b0, 16'd0, 8'd0,
                   ktt_pkg::StSanity};
          cnt_d = '0;
          state_d = ktt_pkg::FsmOut;
        end else if (!f_func && alten_q && f_hasalt && alt_bad) begin
          out_d = {1'b0, 9'(peak_q), 9'(live_q), 9'd0, 1'b0, 16'd0, 8'd0,
                   ktt_pkg::StAlt};
          cnt_d = '0;
          state_d = ktt_pkg::FsmOut;
        end else begin
          scan_start = 1'b1;
          cnt_d = '0;
          state_d = ktt_pkg::FsmDrain;
        end
      end
      ktt_pkg::FsmDrain: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IdxW+1)'(CAPACITY)) begin
          if (f_func) begin
            live_d = live_q - LiveW'(res_q.expired);
            out_d = {1'b0, 9'(peak_q), 9'(live_d), 9'(res_q.expired), 1'b0, 16'd0,
                     8'd0, ktt_pkg::StAged};
            cnt_d = '0;
            state_d = ktt_pkg::FsmOut;
          end else begin
            found_d = res_q.found;
            fresh_d = !res_q.found;
            evict_d = !res_q.found && !res_q.have_free;
            wr_idx_d = res_q.found ? IdxW'(res_q.found_idx) :
                       res_q.have_free ? IdxW'(res_q.free_idx) : IdxW'(res_q.oldest_idx);
            if (!res_q.found && res_q.have_free) live_d = live_q + 1'b1;
            state_d = ktt_pkg::FsmCommit;
          end
        end
      end
      ktt_pkg::FsmCommit: begin
        pv_before_d = cell_pv[wr_idx_q] && !fresh_q;
        wr_en = 1'b1;
        if (live_q > peak_q) peak_d = live_q;
        state_d = ktt_pkg::FsmOut;
        out_v_d = 1'b0;
        cnt_d = '1;
      end
      ktt_pkg::FsmOut: begin
        if (cnt_q == '1) begin
          cnt_d = '0;
          if (found_q)
            out_d[2:0] = (f_haspos && !pv_before_q) ? ktt_pkg::StFix : ktt_pkg::StUpdated;
          else if (evict_q)
            out_d[2:0] = ktt_pkg::StEvicted;
          else
            out_d[2:0] = f_haspos ? ktt_pkg::StFix : ktt_pkg::StNew;
          out_d[55:3] = {1'b0, 9'(peak_q), 9'(live_q), 9'd0, cell_pv[wr_idx_q],
                         cell_cnt[wr_idx_q], 8'(wr_idx_q)};
        end
        if (!out_v_q && cnt_q != '1) begin
          out_v_d = 1'b1;
          state_d = ktt_pkg::FsmIdle;
        end
      end
      default: state_d = ktt_pkg::FsmIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ktt_pkg::FsmIdle;
      live_q  <= '0;
      peak_q  <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= live_d;
      peak_q  <= peak_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  // The result of the last cell is registered once more in res_q.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) item_q <= s_axis_tdata;
    exp_us_q <= 48'(expiry_q) * 48'(ktt_pkg::UsPerMs);
    pos_us_q <= 48'(pstale_q) * 48'(ktt_pkg::UsPerMs);
    res_q <= res_c[CAPACITY];
    out_q <= out_d;
    wr_idx_q <= wr_idx_d;
    fresh_q <= fresh_d;
    evict_q <= evict_d;
    found_q <= found_d;
    pv_before_q <= pv_before_d;
  end

  assign s_axis_tready = (state_q == ktt_pkg::FsmIdle) && !out_v_q;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_q;

endmodule
